// ===== design/pwrw_pkg.sv =====
// Shared types and constants for the pulse width register writer.
package pwrw_pkg;

    localparam int UNIT_W  = 6;
    localparam int CYC_W   = 8;
    localparam int DEV_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int FRAME_W = 24;
    localparam int BIT_W   = 5;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 8;

    localparam logic [BIT_W-1:0] FRAME_BITS = 5'd24;

    localparam logic [UNIT_W-1:0] UNIT_RST = 6'd10;
    localparam logic [CYC_W-1:0]  PRE_RST  = 8'd60;
    localparam logic [CYC_W-1:0]  POST_RST = 8'd60;
    localparam logic [DEV_W-1:0]  DEV_RST  = 7'h53;

    localparam logic [CFG_AW-1:0] CFG_UNIT_CLOCKS    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PRE_CYCLES     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_POST_CYCLES    = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_DEVICE_ADDRESS = 2'd3;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] reg_address;
    } t_item;

    typedef struct packed {
        logic rejected;
        logic frame_done;
        logic busy_res;
        logic clock_active;
        logic line_level;
    } t_result;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_clocks;
        logic [CYC_W-1:0]  pre_cycles;
        logic [CYC_W-1:0]  post_cycles;
        logic [DEV_W-1:0]  device_address;
    } t_cfg;

endpackage

// ===== design/pulse_width_register_writer_core.sv =====
// A transaction's result reaches the master side through the input queue and the output register.
// Throughput: one transaction per cycle when no side stalls; the two-entry input queue and the
// output register let each side stall on its own; the frame sequencer takes one item per cycle.
// Reset (synchronous, active low): queue and output empty, frame idle, line held low,
// registers at unit 10, preamble 60, postamble 60, device address 0x53.
module pulse_width_register_writer_core
    import pwrw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,  // reg_address, write_data
    input  logic              s_axis_tuser,  // command
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata   // line_level, clock_active, busy_res,
                                             // frame_done, rejected, zero pad
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   q_item;
    logic    q_valid;
    logic    q_pop;
    t_result result;

    assign in_item.command     = s_axis_tuser;
    assign in_item.reg_address = s_axis_tdata[7:0];
    assign in_item.write_data  = s_axis_tdata[15:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_clocks    <= UNIT_RST;
            r_cfg.pre_cycles     <= PRE_RST;
            r_cfg.post_cycles    <= POST_RST;
            r_cfg.device_address <= DEV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_UNIT_CLOCKS:    r_cfg.unit_clocks    <= i_cfg_data[UNIT_W-1:0];
                CFG_PRE_CYCLES:     r_cfg.pre_cycles     <= i_cfg_data[CYC_W-1:0];
                CFG_POST_CYCLES:    r_cfg.post_cycles    <= i_cfg_data[CYC_W-1:0];
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[DEV_W-1:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    pwrw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    pwrw_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {3'b000, result};

endmodule

// ===== design/pwrw_front.sv =====
// Input stage: two-entry queue that holds transactions, each with its command bit (tick or write).
module pwrw_front
    import pwrw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic push;
    logic pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_pop;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/pwrw_engine.sv =====
// Frame sequencer: runs the frame into an output register, one transaction per unstalled cycle.
module pwrw_engine
    import pwrw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_START,
        PH_SPACE,
        PH_BITH,
        PH_BITS,
        PH_STOP,
        PH_POST
    } t_phase;

    t_phase             r_phase,  n_phase;
    logic [LEN_W-1:0]   r_count,  n_count;
    logic [BIT_W-1:0]   r_bit,    n_bit;
    logic [FRAME_W-1:0] r_frame,  n_frame;
    logic               r_held,   n_held;
    logic               r_out_valid;
    t_result            r_result, n_result;

    logic [UNIT_W-1:0] unit;
    logic [LEN_W-1:0]  unit_len;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  count_inc;
    logic [BIT_W-1:0]  bit_inc;
    logic              phase_lvl;

    assign o_pop    = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    assign unit      = (i_cfg.unit_clocks == '0) ? UNIT_W'(1) : i_cfg.unit_clocks;
    assign unit_len  = LEN_W'(unit);
    assign count_inc = r_count + LEN_W'(1);
    assign bit_inc   = r_bit + BIT_W'(1);

    always_comb begin
        case (r_phase)
            PH_PRE:  len = LEN_W'(i_cfg.pre_cycles);
            PH_BITH: len = r_frame[FRAME_W-1] ? (unit_len << 1) + unit_len : unit_len;
            PH_STOP: len = (unit_len << 3) + (unit_len << 2) + unit_len;
            PH_POST: len = LEN_W'(i_cfg.post_cycles);
            default: len = unit_len;
        endcase
        case (r_phase)
            PH_START, PH_BITH, PH_STOP, PH_POST: phase_lvl = 1'b1;
            PH_IDLE:                             phase_lvl = r_held;
            default:                             phase_lvl = 1'b0;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_bit    = r_bit;
        n_frame  = r_frame;
        n_held   = r_held;
        n_result = '0;
        n_result.line_level = r_held;
        if (i_item.command) begin
            n_result.busy_res = 1'b1;
            if (r_phase != PH_IDLE) begin
                n_result.rejected = 1'b1;
            end else begin
                n_frame = {i_cfg.device_address, 1'b0, i_item.reg_address, i_item.write_data};
                n_bit   = '0;
                n_count = '0;
                n_phase = (i_cfg.pre_cycles == '0) ? PH_START : PH_PRE;
            end
        end else if (r_phase != PH_IDLE) begin
            n_result.busy_res     = 1'b1;
            n_result.clock_active = 1'b1;
            n_result.line_level   = phase_lvl;
            n_held  = phase_lvl;
            n_count = count_inc;
            if (count_inc >= len) begin
                n_count = '0;
                case (r_phase)
                    PH_PRE:   n_phase = PH_START;
                    PH_START: n_phase = PH_SPACE;
                    PH_SPACE: n_phase = PH_BITH;
                    PH_BITH:  n_phase = PH_BITS;
                    PH_BITS: begin
                        n_frame = r_frame << 1;
                        n_bit   = bit_inc;
                        n_phase = (bit_inc >= FRAME_BITS) ? PH_STOP : PH_BITH;
                    end
                    PH_STOP: begin
                        if (i_cfg.post_cycles == '0) begin
                            n_phase = PH_IDLE;
                            n_result.frame_done = 1'b1;
                        end else begin
                            n_phase = PH_POST;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_result.frame_done = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_bit       <= '0;
            r_frame     <= '0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_bit       <= n_bit;
                r_frame     <= n_frame;
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule
